// ===== rtl/blbi_pkg.sv =====
// Shared types and constants for the battery LED bar indicator.
// Used by blbi_led_sel and battery_led_bar_indicator_unit; no dependencies.
`default_nettype none

package blbi_pkg;

  typedef enum logic [2:0] {
    MODE_OFF       = 3'd0,
    MODE_PRECHARGE = 3'd1,
    MODE_IDLE      = 3'd2,
    MODE_DISCHARGE = 3'd3,
    MODE_CHARGE    = 3'd4,
    MODE_BALANCE   = 3'd5,
    MODE_FAULT     = 3'd6,
    MODE_SHUTDOWN  = 3'd7
  } mode_t;

  localparam logic [3:0]  LED_ALL        = 4'hF;
  localparam logic [3:0]  LED_NONE       = 4'h0;
  localparam logic [31:0] STEP_MS        = 32'd250;
  localparam logic [31:0] SWEEP_2_MS     = 32'd250;
  localparam logic [31:0] SWEEP_3_MS     = 32'd500;
  localparam logic [31:0] SWEEP_4_MS     = 32'd750;
  localparam logic [7:0]  SOC_TH1        = 8'd20;
  localparam logic [7:0]  SOC_TH2        = 8'd40;
  localparam logic [7:0]  SOC_TH3        = 8'd60;
  localparam logic [7:0]  SOC_TH4        = 8'd80;
  localparam logic [15:0] LONG_PRESS_RST = 16'd2000;

  // floor(x / 125) = (x * DIV125_MAGIC) >> DIV125_SHIFT, exact for any 32-bit x
  localparam logic [28:0] DIV125_MAGIC   = 29'h10624DD3;
  localparam int          DIV125_SHIFT   = 35;

  // Stage-1 word handed to the LED selector
  typedef struct packed {
    logic [31:0] elapsed;
    mode_t       mode;
    logic [7:0]  soc;
    logic [3:0]  fault_v;
    logic [3:0]  fill;
    logic [3:0]  walk;
    logic        press;
    logic        long_pulse;
  } stage_t;

endpackage

`default_nettype wire

// ===== rtl/blbi_led_sel.sv =====
// LED pattern selection from the stage-1 word: blink phase by divide-by-250
// of the elapsed mode time, then a per-mode mux. Depends on blbi_pkg.
`default_nettype none

module blbi_led_sel (
  input  wire blbi_pkg::stage_t st,
  output logic [3:0]            led_bits
);

  logic [30:0] half_e;
  logic [59:0] prod;
  logic [1:0]  q_lo;
  logic        blink;
  logic        fast;
  logic        gt1, gt2, gt3, gt4;

  // q = floor(elapsed / 250); blink phase is inverted q bit1, fast phase is inverted q bit0
  assign half_e = st.elapsed[31:1];
  assign prod   = {29'd0, half_e} * {31'd0, blbi_pkg::DIV125_MAGIC};
  assign q_lo   = prod[blbi_pkg::DIV125_SHIFT +: 2];
  assign fast   = ~q_lo[0];
  assign blink  = ~q_lo[1];

  assign gt1 = st.soc > blbi_pkg::SOC_TH1;
  assign gt2 = st.soc > blbi_pkg::SOC_TH2;
  assign gt3 = st.soc > blbi_pkg::SOC_TH3;
  assign gt4 = st.soc > blbi_pkg::SOC_TH4;

  always_comb begin
    case (st.mode)
      blbi_pkg::MODE_OFF: begin
        led_bits = {st.elapsed > blbi_pkg::SWEEP_4_MS,
                    st.elapsed > blbi_pkg::SWEEP_3_MS,
                    st.elapsed > blbi_pkg::SWEEP_2_MS,
                    st.elapsed != 32'd0};
      end
      blbi_pkg::MODE_PRECHARGE: begin
        led_bits = blink ? blbi_pkg::LED_ALL : blbi_pkg::LED_NONE;
      end
      blbi_pkg::MODE_IDLE: begin
        led_bits = {gt4, gt3, gt2, gt1 | fast};
      end
      blbi_pkg::MODE_DISCHARGE: begin
        led_bits = {gt4 & blink,
                    gt3 & (gt4 | blink),
                    gt2 & (gt3 | blink),
                    gt1 ? (gt2 | blink) : fast};
      end
      blbi_pkg::MODE_CHARGE: begin
        led_bits = {gt4 & st.fill[3], gt3 & st.fill[2], gt2 & st.fill[1], st.fill[0]};
      end
      blbi_pkg::MODE_BALANCE: begin
        led_bits = ~st.walk;
      end
      blbi_pkg::MODE_FAULT: begin
        // LED1 carries the MSB of the fault code
        led_bits = {st.fault_v[0], st.fault_v[1], st.fault_v[2], st.fault_v[3]};
      end
      default: begin
        led_bits = blbi_pkg::LED_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/battery_led_bar_indicator_unit.sv =====
// Path: stage 1, then the output register; 1 word per cycle unless out_tready stalls it.
// Stage 1 updates all state (mode timer, patterns, button tracker) on accept and
// registers the elapsed time; stage 2 divides by 250 with one 31x29 multiplier and
// selects the LEDs into the output register. Reset (rst_n low, synchronous) clears
// all state, empties both stages and loads long_press_ms with 2000.
// Depends on blbi_pkg and blbi_led_sel.
`default_nettype none

module battery_led_bar_indicator_unit #(
  parameter int FAULT_WIDTH = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [15:0] cfg_wdata,     // long_press_ms
  input  wire         in_tvalid,
  output logic        in_tready,
  // now_ms[31:0], mode[34:32], soc_percent[42:35], fault_bits[50:43],
  // button_level[51], zero[55:52]
  input  wire  [55:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // led_bits[3:0], press_pulse[4], long_press_pulse[5], zero[7:6]
  output logic [7:0]  out_tdata
);

  localparam int SCAN_W = (FAULT_WIDTH < 8) ? FAULT_WIDTH : 8;

  logic [15:0] long_press_r;
  blbi_pkg::mode_t last_mode_r, last_mode_nxt;
  logic [31:0] mode_time_r, mode_time_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [3:0]  walk_r, walk_nxt;
  logic [31:0] step_time_r, step_time_nxt;
  logic        btn_r, btn_nxt;
  logic [31:0] btn_time_r, btn_time_nxt;
  logic        held_r, held_nxt;

  logic            s1_valid_r;
  blbi_pkg::stage_t s1_r, s1_nxt;
  logic            out_valid_r;
  logic [7:0]      out_data_r;

  logic            accept;
  logic            s1_move;
  logic            out_free;
  logic [31:0]     now;
  blbi_pkg::mode_t mode;
  logic [7:0]      soc;
  logic [7:0]      faults;
  logic            level;
  logic [31:0]     hold_time;
  logic [3:0]      fault_v;
  logic [3:0]      led_bits;

  assign now    = in_tdata[31:0];
  assign mode   = blbi_pkg::mode_t'(in_tdata[34:32]);
  assign soc    = in_tdata[42:35];
  assign faults = in_tdata[50:43];
  assign level  = in_tdata[51];

  assign out_free  = ~out_valid_r | out_tready;
  assign s1_move   = s1_valid_r & out_free;
  assign in_tready = ~s1_valid_r | out_free;
  assign accept    = in_tvalid & in_tready;

  // lowest set fault bit wins
  always_comb begin
    fault_v = 4'd0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (faults[i]) begin
        fault_v = 4'(i + 1);
      end
    end
  end

  always_comb begin
    fill_nxt      = fill_r;
    walk_nxt      = walk_r;
    step_time_nxt = step_time_r;
    if ((now - step_time_r) > blbi_pkg::STEP_MS) begin
      step_time_nxt = now;
      fill_nxt      = (fill_r == 4'hF) ? 4'h0 : {fill_r[2:0], 1'b1};
      walk_nxt      = (walk_r == 4'h0) ? 4'h1 : {walk_r[2:0], 1'b0};
    end

    last_mode_nxt = mode;
    mode_time_nxt = (mode != last_mode_r) ? now : mode_time_r;

    btn_nxt      = level;
    btn_time_nxt = (level != btn_r) ? now : btn_time_r;
    hold_time    = now - btn_time_nxt;
    held_nxt     = level & (hold_time >= {16'd0, long_press_r});

    s1_nxt.elapsed    = now - mode_time_r;
    s1_nxt.mode       = mode;
    s1_nxt.soc        = soc;
    s1_nxt.fault_v    = fault_v;
    s1_nxt.fill       = fill_nxt;
    s1_nxt.walk       = walk_nxt;
    s1_nxt.press      = level & ~btn_r;
    s1_nxt.long_pulse = held_nxt & ~held_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= blbi_pkg::LONG_PRESS_RST;
      last_mode_r  <= blbi_pkg::MODE_OFF;
      mode_time_r  <= '0;
      fill_r       <= '0;
      walk_r       <= '0;
      step_time_r  <= '0;
      btn_r        <= 1'b0;
      btn_time_r   <= '0;
      held_r       <= 1'b0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        long_press_r <= cfg_wdata;
      end
      if (accept) begin
        last_mode_r <= last_mode_nxt;
        mode_time_r <= mode_time_nxt;
        fill_r      <= fill_nxt;
        walk_r      <= walk_nxt;
        step_time_r <= step_time_nxt;
        btn_r       <= btn_nxt;
        btn_time_r  <= btn_time_nxt;
        held_r      <= held_nxt;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (s1_move) begin
      out_data_r <= {2'b00, s1_r.long_pulse, s1_r.press, led_bits};
    end
  end

  blbi_led_sel u_led_sel (
    .st       (s1_r),
    .led_bits (led_bits)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
